// ===== design/rational_time_rescale_nearest_top_assert.svh =====
// Assertion macros shared by the rescale block
`ifndef RATIONAL_TIME_RESCALE_NEAREST_TOP_ASSERT_SVH
`define RATIONAL_TIME_RESCALE_NEAREST_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset
`define RTR_CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rescale check failed");

// Implication whose consequent is checked at the clock edge after the antecedent
`define RTR_CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rescale check failed");

`endif

// ===== design/rtr_pkg.sv =====
`default_nettype none
package rtr_pkg;

    localparam logic [1:0] MODE_CALC = 2'd0;
    localparam logic [1:0] MODE_INV  = 2'd1;
    localparam logic [1:0] MODE_EQ   = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_INV = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic        neg;
        logic [63:0] value;
        logic [30:0] ts;
        logic [30:0] sc;
        logic [31:0] flags;
        logic [63:0] epoch;
        logic        ovf;
        logic [62:0] prod;
    } t_ctx;

    // partial remainder and combined dividend / quotient shift register
    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] dq;
    } t_div;

endpackage
`default_nettype wire

// ===== design/rtr_div8.sv =====
`default_nettype none
module rtr_div8 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  rtr_pkg::t_ctx i_ctx,
    input  rtr_pkg::t_div i_div,
    output logic          o_vld,
    output rtr_pkg::t_ctx o_ctx,
    output rtr_pkg::t_div o_div
);

    rtr_pkg::t_div n_div;
    rtr_pkg::t_div r_div;
    rtr_pkg::t_ctx r_ctx;
    logic          r_vld;

    // eight restoring steps against the source scale
    always_comb begin
        logic [31:0] rm;
        logic [63:0] q;
        logic [32:0] t;
        rm = i_div.rem;
        q  = i_div.dq;
        for (int k = 0; k < 8; k++) begin
            t = {rm, q[63]};
            q = {q[62:0], 1'b0};
            if (t >= {2'b00, i_ctx.ts}) begin
                t    = t - {2'b00, i_ctx.ts};
                q[0] = 1'b1;
            end
            rm = t[31:0];
        end
        n_div.rem = rm;
        n_div.dq  = q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
            r_ctx <= i_ctx;
        end
    end

    assign o_vld = r_vld;
    assign o_ctx = r_ctx;
    assign o_div = r_div;

endmodule
`default_nettype wire

// ===== design/rtr_mul.sv =====
`default_nettype none
module rtr_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  rtr_pkg::t_ctx i_ctx,
    input  rtr_pkg::t_div i_div,
    output logic          o_vld,
    output rtr_pkg::t_ctx o_ctx,
    output rtr_pkg::t_div o_div
);

    logic          r_a_vld;
    rtr_pkg::t_ctx r_a_ctx;
    logic [62:0]   r_plo;
    logic [62:0]   r_phi;
    logic [61:0]   r_part;
    logic [62:0]   n_plo;
    logic [62:0]   n_phi;
    logic [61:0]   n_part;
    logic [94:0]   n_prod;

    logic          r_vld;
    rtr_pkg::t_ctx r_ctx;
    rtr_pkg::t_div r_div;
    rtr_pkg::t_ctx n_ctx;
    rtr_pkg::t_div n_div;

    // whole part arrives in dq, remainder in rem
    assign n_plo  = {31'b0, i_div.dq[31:0]} * {32'b0, i_ctx.sc};
    assign n_phi  = {31'b0, i_div.dq[63:32]} * {32'b0, i_ctx.sc};
    assign n_part = {31'b0, i_div.rem[30:0]} * {31'b0, i_ctx.sc};

    assign n_prod = {r_phi, 32'b0} + {32'b0, r_plo};

    always_comb begin
        n_ctx      = r_a_ctx;
        n_ctx.ovf  = (n_prod[94:63] != 32'b0);
        n_ctx.prod = n_prod[62:0];
        // remainder times scale is below ts * 2^31, so its top 30 bits are below ts
        n_div.rem  = {2'b00, r_part[61:32]};
        n_div.dq   = {r_part[31:0], 32'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_vld   <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctx <= i_ctx;
            r_plo   <= n_plo;
            r_phi   <= n_phi;
            r_part  <= n_part;
            r_ctx   <= n_ctx;
            r_div   <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_ctx = r_ctx;
    assign o_div = r_div;

endmodule
`default_nettype wire

// ===== design/rtr_fin.sv =====
`default_nettype none
module rtr_fin (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  rtr_pkg::t_ctx i_ctx,
    input  rtr_pkg::t_div i_div,
    output logic          o_vld,
    output logic [63:0]   o_value,
    output logic [30:0]   o_scale,
    output logic [31:0]   o_flags,
    output logic [63:0]   o_epoch,
    output logic [1:0]    o_status
);

    logic          r_s_vld;
    rtr_pkg::t_ctx r_s_ctx;
    logic [63:0]   r_sum;
    logic          r_ovf;
    logic          r_frac;
    logic [63:0]   n_sum;
    logic          n_ovf;
    logic          n_frac;
    logic          n_rnd;

    logic          r_vld;
    logic [63:0]   r_value;
    logic [30:0]   r_scale;
    logic [31:0]   r_flags;
    logic [63:0]   r_epoch;
    logic [1:0]    r_status;
    logic [63:0]   n_value;
    logic [30:0]   n_scale;
    logic [31:0]   n_flags;
    logic [63:0]   n_epoch;
    logic [1:0]    n_status;

    // fold the round-up into the carry-in; the limit moves up by one with it
    assign n_frac = (i_div.rem[30:0] != 31'b0);
    assign n_rnd  = n_frac && ({i_div.rem[30:0], 1'b0} >= {1'b0, i_ctx.ts});
    assign n_sum  = {1'b0, i_ctx.prod} + {32'b0, i_div.dq[31:0]} + {63'b0, n_rnd};
    assign n_ovf  = i_ctx.ovf || (n_rnd ? (n_sum > rtr_pkg::SMAX)
                                        : (n_sum >= rtr_pkg::SMAX));

    always_comb begin
        n_value  = 64'b0;
        n_scale  = 31'b0;
        n_flags  = 32'b0;
        n_epoch  = 64'b0;
        n_status = rtr_pkg::ST_OK;
        case (r_s_ctx.mode)
            rtr_pkg::MODE_INV: begin
                n_status = rtr_pkg::ST_INV;
            end
            rtr_pkg::MODE_EQ: begin
                n_value = r_s_ctx.value;
                n_scale = r_s_ctx.ts;
                n_flags = r_s_ctx.flags;
                n_epoch = r_s_ctx.epoch;
            end
            default: begin
                if (r_ovf) begin
                    n_status = rtr_pkg::ST_OVF;
                end else begin
                    n_value = r_s_ctx.neg ? (~r_sum + 64'd1) : r_sum;
                    n_scale = r_s_ctx.sc;
                    n_flags = r_s_ctx.flags | {30'b0, r_frac, 1'b0};
                    n_epoch = r_s_ctx.epoch;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_s_vld <= i_vld;
            r_vld   <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_ctx  <= i_ctx;
            r_sum    <= n_sum;
            r_ovf    <= n_ovf;
            r_frac   <= n_frac;
            r_value  <= n_value;
            r_scale  <= n_scale;
            r_flags  <= n_flags;
            r_epoch  <= n_epoch;
            r_status <= n_status;
        end
    end

    assign o_vld    = r_vld;
    assign o_value  = r_value;
    assign o_scale  = r_scale;
    assign o_flags  = r_flags;
    assign o_epoch  = r_epoch;
    assign o_status = r_status;

endmodule
`default_nettype wire

// ===== design/rational_time_rescale_nearest_top.sv =====
// Rescales a rational timestamp to a new timescale, rounding to nearest.
// Input channel: i_in_valid / o_in_ready carry one request made of
// i_time_value, i_time_scale, i_time_flags, i_time_epoch, i_target_scale.
// Output channel: o_out_valid / i_out_ready carry one result per request:
// o_out_value, o_out_scale, o_out_flags, o_out_epoch, o_status.
// Throughput: one request per cycle while the output is not stalled. The
// depth is set by two restoring dividers at eight quotient bits per stage
// (64-bit whole part over eight stages, 32-bit fractional quotient over
// four) plus a split multiplier.
// Every stage advances together; when the receiver holds i_out_ready low
// with a result waiting, the whole pipe holds and o_in_ready drops in the
// same cycle, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipe; there is no other state.
// Status 1 flags a bad scale or flags word, status 2 an out-of-range result;
// both zero every other output field.
`default_nettype none
`include "rational_time_rescale_nearest_top_assert.svh"
module rational_time_rescale_nearest_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [63:0] i_time_value,
    input  logic signed [31:0] i_time_scale,
    input  logic        [31:0] i_time_flags,
    input  logic signed [63:0] i_time_epoch,
    input  logic signed [31:0] i_target_scale,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_out_value,
    output logic        [30:0] o_out_scale,
    output logic        [31:0] o_out_flags,
    output logic signed [63:0] o_out_epoch,
    output logic        [1:0]  o_status
);

    logic          w_en;
    logic          n_bad;
    rtr_pkg::t_ctx n_ctx;
    rtr_pkg::t_div n_div;
    logic [63:0]   n_mag;

    logic          r_vld;
    rtr_pkg::t_ctx r_ctx;
    rtr_pkg::t_div r_div;

    logic          w_vld [0:12];
    rtr_pkg::t_ctx w_ctx [0:12];
    rtr_pkg::t_div w_div [0:12];
    logic [63:0]   w_value;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign n_bad = (i_time_scale <= 32'sd0) || (i_target_scale <= 32'sd0) ||
                   ((i_time_flags & ~32'd2) != 32'd1);
    assign n_mag = i_time_value[63] ? (~i_time_value + 64'd1) : i_time_value;

    always_comb begin
        n_ctx.mode  = n_bad ? rtr_pkg::MODE_INV :
                      (i_time_scale == i_target_scale) ? rtr_pkg::MODE_EQ
                                                        : rtr_pkg::MODE_CALC;
        n_ctx.neg   = i_time_value[63];
        n_ctx.value = i_time_value;
        n_ctx.ts    = i_time_scale[30:0];
        n_ctx.sc    = i_target_scale[30:0];
        n_ctx.flags = i_time_flags;
        n_ctx.epoch = i_time_epoch;
        n_ctx.ovf   = 1'b0;
        n_ctx.prod  = 63'b0;
        n_div.rem   = 32'b0;
        n_div.dq    = n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctx <= n_ctx;
            r_div <= n_div;
        end
    end

    assign w_vld[0] = r_vld;
    assign w_ctx[0] = r_ctx;
    assign w_div[0] = r_div;

    // whole part and remainder of the magnitude over the source scale
    for (genvar g = 0; g < 8; g++) begin : g_div_whole
        rtr_div8 u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_ctx   (w_ctx[g]),
            .i_div   (w_div[g]),
            .o_vld   (w_vld[g+1]),
            .o_ctx   (w_ctx[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    rtr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[8]),
        .i_ctx   (w_ctx[8]),
        .i_div   (w_div[8]),
        .o_vld   (w_vld[9]),
        .o_ctx   (w_ctx[9]),
        .o_div   (w_div[9])
    );

    // rescaled remainder over the source scale; each of its stages is instantiated outside any loop
    rtr_div8 u_div_frac0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[9]),
        .i_ctx   (w_ctx[9]),
        .i_div   (w_div[9]),
        .o_vld   (w_vld[10]),
        .o_ctx   (w_ctx[10]),
        .o_div   (w_div[10])
    );

    rtr_div8 u_div_frac1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[10]),
        .i_ctx   (w_ctx[10]),
        .i_div   (w_div[10]),
        .o_vld   (w_vld[11]),
        .o_ctx   (w_ctx[11]),
        .o_div   (w_div[11])
    );

    rtr_div8 u_div_frac2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[11]),
        .i_ctx   (w_ctx[11]),
        .i_div   (w_div[11]),
        .o_vld   (w_vld[12]),
        .o_ctx   (w_ctx[12]),
        .o_div   (w_div[12])
    );

    logic          w_vld_f;
    rtr_pkg::t_ctx w_ctx_f;
    rtr_pkg::t_div w_div_f;

    rtr_div8 u_div_frac3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[12]),
        .i_ctx   (w_ctx[12]),
        .i_div   (w_div[12]),
        .o_vld   (w_vld_f),
        .o_ctx   (w_ctx_f),
        .o_div   (w_div_f)
    );

    rtr_fin u_fin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_vld_f),
        .i_ctx    (w_ctx_f),
        .i_div    (w_div_f),
        .o_vld    (o_out_valid),
        .o_value  (w_value),
        .o_scale  (o_out_scale),
        .o_flags  (o_out_flags),
        .o_epoch  (o_out_epoch),
        .o_status (o_status)
    );

    assign o_out_value = w_value;

    `RTR_CHK_IMPL(a_err_zero, i_clk, i_rst_n,
        o_out_valid && (o_status != rtr_pkg::ST_OK),
        (o_out_value == 64'sd0) && (o_out_scale == 31'd0) && (o_out_flags == 32'd0))
    `RTR_CHK_IMPL(a_ok_fields, i_clk, i_rst_n,
        o_out_valid && (o_status == rtr_pkg::ST_OK),
        o_out_flags[0] && ((o_out_flags & ~32'd3) == 32'd0) && (o_out_scale != 31'd0))
    `RTR_CHK_IMPL(a_no_code3, i_clk, i_rst_n,
        o_out_valid, (o_status == rtr_pkg::ST_OK) || (o_status == rtr_pkg::ST_INV) ||
        (o_status == rtr_pkg::ST_OVF))
    `RTR_CHK_NEXT(a_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_value) && $stable(o_status))

endmodule
`default_nettype wire
